FILE: src/dpr_pkg.sv
// Shared types and constants for the disparity-to-point reprojection block.
package dpr_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int CNT_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;

    localparam int BF_W   = 25;
    localparam int FOC_W  = 20;
    localparam int CTR_W  = 19;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 25;

    localparam int DQ_W    = 9;
    localparam int DQ255_W = 17;
    localparam int DEN_W   = 37;
    localparam int PROD_W  = 45;
    localparam int NUM_W   = 44;
    localparam int REM_W   = 54;
    localparam int QUO_W   = 32;
    localparam int DSH_W   = DEN_W + QUO_W - 1;

    localparam logic [CFG_IW-1:0] REG_BF     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_FOCAL  = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CROW   = 3'd2;
    localparam logic [CFG_IW-1:0] REG_CCOL   = 3'd3;
    localparam logic [CFG_IW-1:0] REG_WIDTH  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 3'd5;

    localparam logic [BF_W-1:0]   RST_BF     = 25'd9211167;
    localparam logic [FOC_W-1:0]  RST_FOCAL  = 20'd153361;
    localparam logic [CTR_W-1:0]  RST_CROW   = 19'd94644;
    localparam logic [CTR_W-1:0]  RST_CCOL   = 19'd57181;
    localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd752;
    localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd480;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;
    localparam logic [30:0] Z_MAX   = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DEN,
        ST_MUL_X,
        ST_MUL_Y,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        OP_Z,
        OP_X,
        OP_Y
    } op_t;

endpackage

FILE: src/disparity_to_point_reprojection_top.sv
// Disparity-to-point reprojection: sequencer, shared multiplier and shared divider.
//
// Takes one coded disparity per request in raster order and returns one 3D point per
// request. Row and column are tracked internally; frame_start forces the pixel to row 0,
// column 0, and frame_end marks the last pixel of the frame. Decoded disparity dq (quarter
// steps) gives z = B*1024/(dq*255), x = (256*row-CU)*B*1024/(dq*F*255) and the same for y
// with the column, each truncated toward zero and saturated to Q15.16. A zero disparity
// gives point_valid = 0, z at its maximum and x = y = 0. A pixel with nonzero disparity
// passes through accept, three multiplier steps on the one shared 25x20 multiplier, then
// three quotients of 32 steps, each after a load state, on the one-bit-per-cycle restoring
// divider, then the hand-off to the output register; a zero-disparity pixel goes from
// accept straight to the hand-off. pix_ready is high only while the sequencer is idle.
// The finished result sits in an output register, so the next request is taken while it
// waits for pt_ready. Configuration writes are always taken (cfg_ready is tied high) and
// must only be issued while the block is idle; indexes past the register list are ignored.
module disparity_to_point_reprojection_top
    import dpr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    input  logic                 pix_valid,
    output logic                 pix_ready,
    input  logic [7:0]           disparity_code,
    input  logic                 frame_start,
    output logic                 pt_valid,
    input  logic                 pt_ready,
    output logic signed [31:0]   point_x,
    output logic signed [31:0]   point_y,
    output logic [30:0]          point_z,
    output logic                 point_valid,
    output logic                 frame_end
);

    // configuration registers
    logic [BF_W-1:0]   bf_reg;
    logic [FOC_W-1:0]  focal_reg;
    logic [CTR_W-1:0]  crow_reg;
    logic [CTR_W-1:0]  ccol_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // control
    state_t            state_reg, state_next;
    op_t               op_reg;
    logic [4:0]        bit_cnt_reg;
    logic [CNT_W-1:0]  col_cnt_reg;
    logic [ROW_W-1:0]  row_cnt_reg;
    logic              out_valid_reg;

    // per-pixel payload
    logic [DQ255_W-1:0] dq255_reg;
    logic               zero_reg;
    logic               fend_reg;
    logic [ROW_W-1:0]   row_reg;
    logic [CNT_W-1:0]   col_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [CTR_W-1:0]   magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    logic [NUM_W-1:0]   numx_reg, numy_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [DSH_W-1:0]   dsh_reg;
    logic [QUO_W-1:0]   quo_reg;
    logic [30:0]        rz_reg;
    logic [31:0]        rx_reg, ry_reg;

    // output register
    logic [31:0] px_reg, py_reg;
    logic [30:0] pz_reg;
    logic        pv_reg, pf_reg;

    // control decode
    logic accept, out_load, div_last;
    logic [FOC_W-1:0] mul_b;
    logic [BF_W-1:0]  mul_a;
    logic [PROD_W-1:0] product;

    // ---------------------------------------------------------------
    // Pixel position and disparity decode at the request
    // ---------------------------------------------------------------
    logic [SIZE_W-1:0] w_eff, h_eff;
    logic [CNT_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic              row_end, frm_end;
    logic [DQ_W-1:0]   dq;
    logic [DQ255_W-1:0] dq255;

    always_comb
    begin
        if (width_reg == '0)
            w_eff = SIZE_W'(1);
        else if (width_reg > SIZE_W'(MAX_WIDTH))
            w_eff = SIZE_W'(MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = SIZE_W'(1);
        else if (height_reg > SIZE_W'(MAX_HEIGHT))
            h_eff = SIZE_W'(MAX_HEIGHT);
        else
            h_eff = height_reg;

        col_cur = frame_start ? '0 : col_cnt_reg;
        row_cur = frame_start ? '0 : row_cnt_reg;
        row_end = (SIZE_W'(col_cur) + SIZE_W'(1)) >= w_eff;
        frm_end = row_end && ((SIZE_W'(row_cur) + SIZE_W'(1)) >= h_eff);

        // below 128: 4*floor(code/4); else 2*code - 128
        if (disparity_code[7])
            dq = {disparity_code, 1'b0} - DQ_W'(128);
        else
            dq = {2'b00, disparity_code[6:2], 2'b00};
        dq255 = {dq, 8'b0} - DQ255_W'(dq);
    end

    // ---------------------------------------------------------------
    // Shared multiplier and offset magnitudes
    // ---------------------------------------------------------------
    logic signed [CTR_W:0] dx, dy;
    logic [FOC_W-1:0] f_eff;

    always_comb
    begin
        f_eff   = (focal_reg == '0) ? FOC_W'(1) : focal_reg;
        dx      = $signed({1'b0, row_reg, 8'b0}) - $signed({1'b0, crow_reg});
        dy      = $signed({1'b0, col_reg, 8'b0}) - $signed({1'b0, ccol_reg});
        product = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // ---------------------------------------------------------------
    // Shared restoring divider step: one quotient bit per cycle
    // ---------------------------------------------------------------
    logic             ge;
    logic [REM_W-1:0] rem_step;
    logic [QUO_W-1:0] quo_step;
    logic [REM_W-1:0] load_num;
    logic [DEN_W-1:0] load_den;
    logic             cur_neg;
    logic [31:0]      coord_sat;

    always_comb
    begin
        ge       = {{(DSH_W - REM_W){1'b0}}, rem_reg} >= dsh_reg;
        rem_step = ge ? (rem_reg - dsh_reg[REM_W-1:0]) : rem_reg;
        quo_step = {quo_reg[QUO_W-2:0], ge};

        unique case (op_reg)
            OP_Z:
            begin
                load_num = {{(REM_W - BF_W - 10){1'b0}}, bf_reg, 10'b0};
                load_den = {{(DEN_W - DQ255_W){1'b0}}, dq255_reg};
                cur_neg  = 1'b0;
            end
            OP_X:
            begin
                load_num = {numx_reg, 10'b0};
                load_den = den_reg;
                cur_neg  = negx_reg;
            end
            OP_Y:
            begin
                load_num = {numy_reg, 10'b0};
                load_den = den_reg;
                cur_neg  = negy_reg;
            end
            default:
            begin
                load_num = '0;
                load_den = '0;
                cur_neg  = 1'b0;
            end
        endcase

        // quotient bit 31 set means the magnitude is at least 2^31
        if (quo_step[QUO_W-1])
            coord_sat = cur_neg ? SAT_NEG : SAT_POS;
        else
            coord_sat = cur_neg ? (~quo_step + 32'd1) : quo_step;
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pix_valid)
                    state_next = (dq == '0) ? ST_FINISH : ST_MUL_DEN;
            end
            ST_MUL_DEN:  state_next = ST_MUL_X;
            ST_MUL_X:    state_next = ST_MUL_Y;
            ST_MUL_Y:    state_next = ST_DIV_LOAD;
            ST_DIV_LOAD: state_next = ST_DIV_RUN;
            ST_DIV_RUN:
            begin
                if (bit_cnt_reg == '0)
                    state_next = (op_reg == OP_Y) ? ST_FINISH : ST_DIV_LOAD;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || pt_ready)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: decoded controls
    // ---------------------------------------------------------------
    always_comb
    begin
        pix_ready = 1'b0;
        out_load  = 1'b0;
        div_last  = 1'b0;
        mul_a     = bf_reg;
        mul_b     = {1'b0, magx_reg};
        unique case (state_reg)
            ST_IDLE:     pix_ready = 1'b1;
            ST_MUL_DEN:
            begin
                mul_a = {{(BF_W - DQ255_W){1'b0}}, dq255_reg};
                mul_b = f_eff;
            end
            ST_MUL_X:    mul_b = {1'b0, magx_reg};
            ST_MUL_Y:    mul_b = {1'b0, magy_reg};
            ST_DIV_LOAD: ;
            ST_DIV_RUN:  div_last = (bit_cnt_reg == '0);
            ST_FINISH:   out_load = !out_valid_reg || pt_ready;
            default:     ;
        endcase
        accept = pix_valid && pix_ready;
    end

    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_Z;
            bit_cnt_reg   <= '0;
            col_cnt_reg   <= '0;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            bf_reg        <= RST_BF;
            focal_reg     <= RST_FOCAL;
            crow_reg      <= RST_CROW;
            ccol_reg      <= RST_CCOL;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_BF:     bf_reg     <= cfg_data[BF_W-1:0];
                    REG_FOCAL:  focal_reg  <= cfg_data[FOC_W-1:0];
                    REG_CROW:   crow_reg   <= cfg_data[CTR_W-1:0];
                    REG_CCOL:   ccol_reg   <= cfg_data[CTR_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg_data[SIZE_W-1:0];
                    REG_HEIGHT: height_reg <= cfg_data[SIZE_W-1:0];
                    default:    ;
                endcase
            end

            if (accept)
            begin
                op_reg <= OP_Z;
                if (row_end)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= frm_end ? '0 : row_cur + ROW_W'(1);
                end
                else
                begin
                    col_cnt_reg <= col_cur + CNT_W'(1);
                    row_cnt_reg <= row_cur;
                end
            end

            if (state_reg == ST_DIV_LOAD)
                bit_cnt_reg <= 5'd31;
            else if (state_reg == ST_DIV_RUN)
                bit_cnt_reg <= bit_cnt_reg - 5'd1;

            if (div_last)
            begin
                unique case (op_reg)
                    OP_Z:    op_reg <= OP_X;
                    OP_X:    op_reg <= OP_Y;
                    OP_Y:    op_reg <= OP_Z;
                    default: op_reg <= OP_Z;
                endcase
            end

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (pt_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dq255_reg <= dq255;
            zero_reg  <= (dq == '0);
            fend_reg  <= frm_end;
            row_reg   <= row_cur;
            col_reg   <= col_cur;
        end

        unique case (state_reg)
            ST_MUL_DEN:
            begin
                den_reg  <= product[DEN_W-1:0];
                negx_reg <= dx[CTR_W];
                negy_reg <= dy[CTR_W];
                magx_reg <= dx[CTR_W] ? CTR_W'(-dx) : dx[CTR_W-1:0];
                magy_reg <= dy[CTR_W] ? CTR_W'(-dy) : dy[CTR_W-1:0];
            end
            ST_MUL_X: numx_reg <= product[NUM_W-1:0];
            ST_MUL_Y: numy_reg <= product[NUM_W-1:0];
            ST_DIV_LOAD:
            begin
                rem_reg <= load_num;
                dsh_reg <= {load_den, {(QUO_W - 1){1'b0}}};
                quo_reg <= '0;
            end
            ST_DIV_RUN:
            begin
                rem_reg <= rem_step;
                dsh_reg <= dsh_reg >> 1;
                quo_reg <= quo_step;
            end
            default: ;
        endcase

        if (div_last)
        begin
            unique case (op_reg)
                OP_Z:    rz_reg <= quo_step[QUO_W-1] ? Z_MAX : quo_step[30:0];
                OP_X:    rx_reg <= coord_sat;
                OP_Y:    ry_reg <= coord_sat;
                default: ;
            endcase
        end

        if (out_load)
        begin
            px_reg <= zero_reg ? 32'd0 : rx_reg;
            py_reg <= zero_reg ? 32'd0 : ry_reg;
            pz_reg <= zero_reg ? Z_MAX : rz_reg;
            pv_reg <= !zero_reg;
            pf_reg <= fend_reg;
        end
    end

    assign pt_valid    = out_valid_reg;
    assign point_x     = $signed(px_reg);
    assign point_y     = $signed(py_reg);
    assign point_z     = pz_reg;
    assign point_valid = pv_reg;
    assign frame_end   = pf_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pt_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result appeared without a finished sequence");

    a_invalid_point: assert property (@(posedge clk) disable iff (!rst_n)
        (pt_valid && !point_valid) |->
            (point_z == Z_MAX && point_x == 32'sd0 && point_y == 32'sd0))
        else $error("zero-disparity point carries nonzero coordinates");

    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV_RUN && bit_cnt_reg == 5'd0) |=>
            (state_reg == ST_DIV_LOAD || state_reg == ST_FINISH))
        else $error("divider did not stop after 32 steps");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && pix_ready) |=> !pix_ready)
        else $error("request taken while previous pixel still in work");

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the disparity-to-point reprojection block.
module tb
    import dpr_pkg::*;
();

    // Run bounds. The watchdog limit assumes every pixel runs the full divider
    // sequence plus the longest source gap and sink stall, with room to spare.
    localparam int LIMIT_CYCLES  = 1_500_000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 250;
    localparam int HOLD_CYCLES   = 800;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 250;
    localparam int MAX_REPORTS   = 10;

    // Index codes past the end of the register file; writes to them are dropped.
    localparam logic [CFG_IW-1:0] IDX_SPARE_A = 3'd6;
    localparam logic [CFG_IW-1:0] IDX_SPARE_B = 3'd7;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0]        z;
        logic               valid;
        logic               fend;
    } point_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_IW-1:0]   cfg_index;
    logic [CFG_DW-1:0]   cfg_data;
    logic                pix_valid;
    logic                pix_ready;
    logic [7:0]          disparity_code;
    logic                frame_start;
    logic                pt_valid;
    logic                pt_ready;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic [30:0]         point_z;
    logic                point_valid;
    logic                frame_end;

    disparity_to_point_reprojection_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pix_valid      (pix_valid),
        .pix_ready      (pix_ready),
        .disparity_code (disparity_code),
        .frame_start    (frame_start),
        .pt_valid       (pt_valid),
        .pt_ready       (pt_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .point_z        (point_z),
        .point_valid    (point_valid),
        .frame_end      (frame_end)
    );

    // Shadow copy of the camera registers and the raster position, kept in
    // step with every accepted write and request.
    logic [BF_W-1:0]   bf_q8;
    logic [FOC_W-1:0]  focal_q8;
    logic [CTR_W-1:0]  crow_q8;
    logic [CTR_W-1:0]  ccol_q8;
    logic [SIZE_W-1:0] width_px;
    logic [SIZE_W-1:0] height_px;
    logic [CNT_W-1:0]  pix_col;
    logic [ROW_W-1:0]  pix_row;

    point_t expected_points[$];
    int     bad_points;
    int     cycle_count;

    // Source/sink pacing controls: calm = no idle cycles, hold = long sink stall.
    logic   tx_calm;
    logic   rx_calm;
    logic   rx_hold;
    event   hold_go;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // offset*mul/den truncated toward zero, saturated to a signed 32-bit value.
    function automatic logic [31:0] scale_coord(input longint offset,
                                                input longint unsigned mul,
                                                input longint unsigned den);
        longint unsigned mag;
        longint unsigned q;
        mag = (offset < 0) ? -offset : offset;
        q   = mag * mul / den;
        if (offset < 0)
            return (q >= 64'h8000_0000) ? SAT_NEG : 32'(64'd0 - q);
        return (q > 64'h7FFF_FFFF) ? SAT_POS : q[31:0];
    endfunction

    // Zero maps to one, anything above the frame limit is capped.
    function automatic int unsigned frame_dim(input logic [SIZE_W-1:0] sz, input int unsigned cap);
        if (sz == '0)
            return 1;
        return (sz > cap) ? cap : sz;
    endfunction

    function automatic void apply_reg(input logic [CFG_IW-1:0] idx,
                                      input logic [CFG_DW-1:0] data);
        unique case (idx)
            REG_BF:     bf_q8     = data[BF_W-1:0];
            REG_FOCAL:  focal_q8  = data[FOC_W-1:0];
            REG_CROW:   crow_q8   = data[CTR_W-1:0];
            REG_CCOL:   ccol_q8   = data[CTR_W-1:0];
            REG_WIDTH:  width_px  = data[SIZE_W-1:0];
            REG_HEIGHT: height_px = data[SIZE_W-1:0];
            default:    ;
        endcase
    endfunction

    // Works out the point for one pixel and advances the raster position.
    function automatic void predict_point(input logic [7:0] code, input logic fs,
                                          output point_t p);
        logic [DQ_W-1:0]  dq;
        longint unsigned  num;
        longint unsigned  den;
        longint unsigned  zq;
        longint unsigned  foc;
        int unsigned      w;
        int unsigned      h;
        logic             row_done;
        w   = frame_dim(width_px, MAX_WIDTH);
        h   = frame_dim(height_px, MAX_HEIGHT);
        foc = (focal_q8 == '0) ? 1 : focal_q8;
        if (fs)
        begin
            pix_col = '0;
            pix_row = '0;
        end
        // quarter-step disparity: fine codes drop the low two bits,
        // coarse codes step by half a pixel
        dq = (code < 8'd128) ? {1'b0, code & 8'hFC} : ({code, 1'b0} - 9'd128);
        if (dq == '0)
        begin
            p.x     = '0;
            p.y     = '0;
            p.z     = Z_MAX;
            p.valid = 1'b0;
        end
        else
        begin
            num     = longint'(bf_q8) * 1024;
            zq      = num / (longint'(dq) * 255);
            den     = longint'(dq) * foc * 255;
            p.x     = scale_coord(longint'(pix_row) * 256 - longint'(crow_q8), num, den);
            p.y     = scale_coord(longint'(pix_col) * 256 - longint'(ccol_q8), num, den);
            p.z     = (zq > 64'h7FFF_FFFF) ? Z_MAX : zq[30:0];
            p.valid = 1'b1;
        end
        // counters may sit past a size that was just reduced: treat as end of row/frame
        row_done = (pix_col + 1 >= w);
        p.fend   = row_done && (pix_row + 1 >= h);
        if (row_done)
        begin
            pix_col = '0;
            pix_row = p.fend ? '0 : pix_row + 1'b1;
        end
        else
            pix_col = pix_col + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One pixel request. Valid is only dropped when a gap is drawn, so a
    // back-to-back request never sees valid lowered and raised in one step.
    task automatic send_pixel(input logic [7:0] code, input logic fs);
        int unsigned gap;
        point_t      want;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid      <= 1'b1;
        disparity_code <= code;
        frame_start    <= fs;
        do @(posedge clk); while (!pix_ready);
        predict_point(code, fs, want);
        expected_points.push_back(want);
    endtask

    // Leading edge first, so two writes in a row never collide on cfg_valid.
    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_reg(idx, data);
    endtask

    // Block is idle once every outstanding point is back; every pixel yields one.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Decoder corners under reset calibration: zero disparity codes, both
    // edges of the fine/coarse split, the top code, and a restart mid-frame.
    task automatic test_decode_corners();
        send_pixel(8'd0,   1'b1);
        send_pixel(8'd3,   1'b0);
        send_pixel(8'd4,   1'b0);
        send_pixel(8'd5,   1'b0);
        send_pixel(8'd127, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd129, 1'b0);
        send_pixel(8'd254, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd130, 1'b1);
        send_pixel(8'd1,   1'b0);
    endtask

    // Register extremes: saturation both ways, zero focal length, zero and
    // oversized frame dimensions, unused register indexes.
    task automatic test_register_corners();
        wait_idle();
        write_reg(REG_BF,     25'h1FF_FFFF);
        write_reg(REG_FOCAL,  '0);
        write_reg(REG_CROW,   '0);
        write_reg(REG_CCOL,   25'h7_FFFF);
        write_reg(REG_WIDTH,  25'd1);
        write_reg(REG_HEIGHT, 25'd3);
        send_pixel(8'd4,   1'b1);
        send_pixel(8'd4,   1'b0);
        send_pixel(8'd255, 1'b0);

        wait_idle();
        write_reg(REG_BF,     '0);
        write_reg(REG_FOCAL,  25'hF_FFFF);
        write_reg(REG_CROW,   25'h7_FFFF);
        write_reg(REG_CCOL,   '0);
        write_reg(REG_WIDTH,  '0);
        write_reg(REG_HEIGHT, '0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd2,   1'b0);

        // all-ones data: upper bits are dropped, sizes land on 2047 and cap at the max
        wait_idle();
        write_reg(REG_BF,     RST_BF);
        write_reg(REG_FOCAL,  CFG_DW'(RST_FOCAL));
        write_reg(REG_WIDTH,  25'h1FF_FFFF);
        write_reg(REG_HEIGHT, 25'h1FF_FFFF);
        write_reg(IDX_SPARE_A, CFG_DW'($urandom()));
        write_reg(IDX_SPARE_B, CFG_DW'($urandom()));
        send_pixel(8'd64, 1'b1);
        send_pixel(8'd200, 1'b0);
    endtask

    // Shrink width and then height while the counters sit beyond the new size.
    task automatic test_shrink_frame();
        wait_idle();
        write_reg(REG_WIDTH,  25'd16);
        write_reg(REG_HEIGHT, 25'd16);
        send_pixel(8'd100, 1'b1);
        for (int k = 0; k < 5; k++)
            send_pixel(8'd140, 1'b0);
        wait_idle();
        write_reg(REG_WIDTH, 25'd4);
        send_pixel(8'd60, 1'b0);
        wait_idle();
        write_reg(REG_HEIGHT, 25'd1);
        for (int k = 0; k < 4; k++)
            send_pixel(8'd180, 1'b0);
    endtask

    // Sink stalls for a long stretch while the source keeps offering, so the
    // output register and the sequencer both fill and pix_ready drops.
    task automatic test_output_stall();
        wait_idle();
        tx_calm = 1'b1;
        -> hold_go;
        for (int k = 0; k < 24; k++)
            send_pixel(8'($urandom_range(0, 255)), k == 0);
        tx_calm = 1'b0;
    endtask

    // Random calibration per phase, mostly small frames so frame ends are
    // frequent, with occasional restarts and a bias toward decoder corners.
    task automatic test_random_frames();
        logic [7:0] code;
        logic       fs;
        for (int phase = 0; phase < RAND_PHASES; phase++)
        begin
            wait_idle();
            case ($urandom_range(0, 3))
                0:       write_reg(REG_BF, '0);
                1:       write_reg(REG_BF, 25'h1FF_FFFF);
                default: write_reg(REG_BF, CFG_DW'($urandom()));
            endcase
            case ($urandom_range(0, 4))
                0:       write_reg(REG_FOCAL, '0);
                1:       write_reg(REG_FOCAL, CFG_DW'($urandom_range(1, 4095)));
                default: write_reg(REG_FOCAL, CFG_DW'($urandom_range(1, 1048575)));
            endcase
            write_reg(REG_CROW,
                      CFG_DW'($urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom()));
            write_reg(REG_CCOL,
                      CFG_DW'($urandom_range(0, 1) ? $urandom_range(0, 4095) : $urandom()));
            case ($urandom_range(0, 7))
                0:       write_reg(REG_WIDTH, '0);
                1:       write_reg(REG_WIDTH, CFG_DW'($urandom_range(1024, 2047)));
                default: write_reg(REG_WIDTH, CFG_DW'($urandom_range(1, 16)));
            endcase
            case ($urandom_range(0, 7))
                0:       write_reg(REG_HEIGHT, '0);
                1:       write_reg(REG_HEIGHT, CFG_DW'($urandom_range(1024, 2047)));
                default: write_reg(REG_HEIGHT, CFG_DW'($urandom_range(1, 8)));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B,
                          CFG_DW'($urandom()));

            // each side runs with no idle cycles in about a quarter of the phases, drawn independently
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                case ($urandom_range(0, 9))
                    0:       code = 8'($urandom_range(0, 3));
                    1:       code = 8'($urandom_range(124, 131));
                    2:       code = 8'($urandom_range(250, 255));
                    default: code = 8'($urandom_range(0, 255));
                endcase
                if (k == 0)
                    fs = 1'($urandom_range(0, 1));
                else
                    fs = ($urandom_range(0, 63) == 0);
                send_pixel(code, fs);
            end
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sink: per-result random stall, plus the long hold on request
    // ------------------------------------------------------------------
    initial
    begin : point_sink
        int unsigned stall;
        pt_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 11);
            if (stall > 0 || rx_hold)
            begin
                pt_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (rx_hold) @(posedge clk);
            end
            pt_ready <= 1'b1;
            do @(posedge clk); while (!pt_valid);
        end
    end

    // Long sink hold, counted here so the source keeps running meanwhile.
    initial
    begin : output_hold
        rx_hold = 1'b0;
        forever
        begin
            @(hold_go);
            rx_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Checker: each accepted point against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : point_check
        point_t want;
        if (rst_n && pt_valid && pt_ready)
        begin
            if (expected_points.size() == 0)
            begin
                bad_points++;
                if (bad_points <= MAX_REPORTS)
                    $display("point with none outstanding: x=%0d y=%0d z=%0d v=%0b fe=%0b",
                             point_x, point_y, point_z, point_valid, frame_end);
            end
            else
            begin
                want = expected_points.pop_front();
                if (point_x !== want.x || point_y !== want.y || point_z !== want.z ||
                    point_valid !== want.valid || frame_end !== want.fend)
                begin
                    bad_points++;
                    if (bad_points <= MAX_REPORTS)
                        $display({"point mismatch: exp x=%0d y=%0d z=%0d v=%0b fe=%0b",
                                  " | got x=%0d y=%0d z=%0d v=%0b fe=%0b"},
                                 $signed(want.x), $signed(want.y), want.z, want.valid,
                                 want.fend, point_x, point_y, point_z, point_valid,
                                 frame_end);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_BF;
        cfg_data       = '0;
        pix_valid      = 1'b0;
        disparity_code = '0;
        frame_start    = 1'b0;
        tx_calm        = 1'b0;
        rx_calm        = 1'b0;
        bad_points     = 0;
        cycle_count    = 0;

        // shadow state matches the block's reset values
        bf_q8     = RST_BF;
        focal_q8  = RST_FOCAL;
        crow_q8   = RST_CROW;
        ccol_q8   = RST_CCOL;
        width_px  = RST_WIDTH;
        height_px = RST_HEIGHT;
        pix_col   = '0;
        pix_row   = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_decode_corners();
        test_register_corners();
        test_shrink_frame();
        test_output_stall();
        test_random_frames();

        // drain, then give the datapath time to show any stray point
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_points == 0 && expected_points.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
